/* rtl/swmf_pkg.sv */
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types, sizes and helpers of the 2D sliding window median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int MAX_WINDOW   = 7;
  localparam int MAX_WIDTH    = 1024;
  localparam int PIXEL_BITS   = 16;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int WIN_ELEMS    = MAX_WINDOW * MAX_WINDOW;
  localparam int HIST_ROWS    = MAX_WINDOW - 1;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int K_BITS       = $clog2(MAX_WINDOW + 1);
  localparam int RANK_BITS    = $clog2(WIN_ELEMS);
  localparam int CFG_BITS     = 13;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WINDOW = 2'd2
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [HIST_ROWS-1:0]  hist_t;
  typedef pix_t [WIN_ELEMS-1:0]  win_t;

  // Control that travels alongside a window through the sorting stages.
  typedef struct packed {
    logic emit;
    logic last;
  } flags_t;

  // Ascending sorted position of the median for a k x k window.
  function automatic logic [RANK_BITS-1:0] median_rank(input logic [K_BITS-1:0] k);
    return RANK_BITS'((32'(k) * 32'(k)) >> 1);
  endfunction

endpackage

/* rtl/swmf_median.sv */
// ----------------------------------------------------------------------------
// swmf_median
// Rank-based median selection over the window, two register stages.
// ----------------------------------------------------------------------------
module swmf_median (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  swmf_pkg::flags_t        flags_in,
  input  swmf_pkg::win_t          window,
  input  logic [swmf_pkg::K_BITS-1:0] k,
  output swmf_pkg::flags_t        flags_out,
  output swmf_pkg::pix_t          median
);
  import swmf_pkg::*;

  logic [WIN_ELEMS-1:0] active;
  logic [WIN_ELEMS-1:0] lt_next [WIN_ELEMS];
  logic [WIN_ELEMS-1:0] lt      [WIN_ELEMS];
  win_t                 vals_a;
  win_t                 vals_b;
  flags_t               flags_a;
  logic [RANK_BITS-1:0] rank   [WIN_ELEMS];
  logic [RANK_BITS-1:0] target;

  for (genvar e = 0; e < WIN_ELEMS; e++) begin : g_act
    assign active[e] = (K_BITS'(e / MAX_WINDOW) < k) && (K_BITS'(e % MAX_WINDOW) < k);
  end

  // Ties are broken by element index so that every active element has its own rank.
  always_comb begin
    for (int i = 0; i < WIN_ELEMS; i++) begin
      for (int j = 0; j < WIN_ELEMS; j++) begin
        lt_next[i][j] = active[j] && (i != j) &&
                        ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_a   <= '0;
      flags_out <= '0;
    end else if (en) begin
      flags_a   <= flags_in;
      flags_out <= flags_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt     <= lt_next;
      vals_a <= window;
      vals_b <= vals_a;
      target <= median_rank(k);
      for (int i = 0; i < WIN_ELEMS; i++) begin
        rank[i] <= active[i] ? RANK_BITS'($countones(lt[i])) : '1;
      end
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < WIN_ELEMS; i++) begin
      if (rank[i] == target) median = median | vals_b[i];
    end
  end

endmodule

/* rtl/sliding_window_median_filter_2d.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_filter_2d
// k x k median over a raster pixel stream, valid region only.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless the sink stalls; the column
// history memory does one read and one write per accepted pixel, with
// forwarding for back-to-back same-column use.
// Reset: synchronous; clears counters and pipeline, sets 640 x 480, k = 3.
// A width, height or window write restarts the frame at row 0, column 0.
module sliding_window_median_filter_2d (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] pixel_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] median_value
  output logic                          m_axis_tlast,   // frame_last
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [swmf_pkg::CFG_BITS-1:0] cfg_data
);
  import swmf_pkg::*;

  logic [COL_BITS:0]   width;
  logic [ROW_BITS:0]   height;
  logic [K_BITS-1:0]   k;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic                en;
  logic                accept;

  logic                s1_valid;
  pix_t                s1_pix;
  logic [COL_BITS-1:0] s1_col;
  flags_t              s1_flags;
  hist_t               rd_data;
  hist_t               fwd_data;
  logic                fwd;
  hist_t               hist;
  hist_t               wr_data;
  hist_t               line_mem [MAX_WIDTH];

  win_t                window;
  flags_t              s2_flags;
  flags_t              med_flags;
  pix_t                median;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // Configuration is stored already saturated to its legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= (COL_BITS+1)'(640);
      height <= (ROW_BITS+1)'(480);
      k      <= K_BITS'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH: begin
          if (cfg_data[10:0] == '0) width <= (COL_BITS+1)'(1);
          else if (32'(cfg_data[10:0]) > MAX_WIDTH) width <= (COL_BITS+1)'(MAX_WIDTH);
          else width <= (COL_BITS+1)'(cfg_data[10:0]);
        end
        REG_HEIGHT: begin
          if (cfg_data == '0) height <= (ROW_BITS+1)'(1);
          else if (32'(cfg_data) > HEIGHT_LIMIT) height <= (ROW_BITS+1)'(HEIGHT_LIMIT);
          else height <= (ROW_BITS+1)'(cfg_data);
        end
        REG_WINDOW: begin
          k <= (cfg_data[2:0] == '0) ? K_BITS'(1) : K_BITS'(cfg_data[2:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                               cfg_index == REG_WINDOW)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if ((COL_BITS+1)'(col) + 1'b1 >= width) begin
        col <= '0;
        row <= ((ROW_BITS+1)'(row) + 1'b1 >= height) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Stage 1: pixel with its read of the column history.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flags <= '0;
    end else if (en) begin
      s1_valid      <= accept;
      s1_flags.emit <= accept && ((ROW_BITS+1)'(row) + 1'b1 >= (ROW_BITS+1)'(k)) &&
                       ((COL_BITS+1)'(col) + 1'b1 >= (COL_BITS+1)'(k));
      s1_flags.last <= ((ROW_BITS+1)'(row) == height - 1'b1) &&
                       ((COL_BITS+1)'(col) == width - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix   <= s_axis_tdata;
      s1_col   <= col;
      rd_data  <= line_mem[col];
      fwd      <= s1_valid && (s1_col == col);
      fwd_data <= wr_data;
      if (s1_valid) line_mem[s1_col] <= wr_data;
    end
  end

  // The history word holds the same column of the previous rows, newest first.
  always_comb begin
    hist       = fwd ? fwd_data : rd_data;
    wr_data[0] = s1_pix;
    for (int r = 1; r < HIST_ROWS; r++) wr_data[r] = hist[r-1];
  end

  // Window: column 0 is the newest; row 0 of each column is the current row.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_flags <= '0;
    end else if (en) begin
      s2_flags <= s1_valid ? s1_flags : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      window[0] <= s1_pix;
      for (int r = 1; r < MAX_WINDOW; r++) window[r] <= hist[r-1];
      for (int e = MAX_WINDOW; e < WIN_ELEMS; e++) window[e] <= window[e-MAX_WINDOW];
    end
  end

  swmf_median u_median (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .flags_in  (s2_flags),
    .window    (window),
    .k         (k),
    .flags_out (med_flags),
    .median    (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= med_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= median;
      m_axis_tlast <= med_flags.last;
    end
  end

endmodule

/* rtl/swmf_checker.sv */
// ----------------------------------------------------------------------------
// swmf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module swmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A word held back by the sink keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // With the output register empty the block always takes a pixel.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // The output is also not valid just after reset is released.
  a_depth: assert property (@(posedge clk)
    $past(rst) |=> !m_axis_tvalid)
    else $error("output valid too soon after reset");

endmodule

bind sliding_window_median_filter_2d swmf_checker u_swmf_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k x k sliding window median filter: directed
// frames with known medians, then random frame geometries and pixel words,
// all checked word by word, the random ones against a behavioral median predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import swmf_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int         LIMIT     = 400000;
  localparam int         SETTLE    = 12;

  typedef struct {
    pix_t med;
    logic last;
  } median_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [12:0] val;
    bit         typed;
    bit         has_res;
    pix_t       pix;
    pix_t       med;
    logic       last;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // Predictor state.
  pix_t        line_mem [MAX_WINDOW][MAX_WIDTH];
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [2:0]  ksize_reg;
  int unsigned col_cnt, row_cnt;

  median_t medians_due[$];
  step_t   plan[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      pixels_sent = 0;
  bit      no_idle = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  sliding_window_median_filter_2d dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sink side: random ready, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: median %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        median_t e;
        e = medians_due.pop_front();
        if (e.med !== m_axis_tdata || e.last !== m_axis_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected median %h last %b, got %h last %b",
                     e.med, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  function automatic void model_reset();
    col_cnt = 0;
    row_cnt = 0;
    width_reg = 11'd640;
    height_reg = 13'd480;
    ksize_reg = 3'd3;
  endfunction

  function automatic void model_config(logic [1:0] idx, logic [12:0] val);
    if (idx == REG_WIDTH) width_reg = val[10:0];
    else if (idx == REG_HEIGHT) height_reg = val;
    else if (idx == REG_WINDOW) ksize_reg = val[2:0];
    else return;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  // Stores the pixel and returns 1 when it completes a fully covered window.
  function automatic bit filter_pixel(pix_t pix, output median_t res);
    int unsigned w, h, k, col, row, top, left, n, slot;
    pix_t win [WIN_ELEMS];
    pix_t v;
    int j;
    bit hit;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    k = (ksize_reg == 0) ? 1 : ksize_reg;
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    line_mem[row % MAX_WINDOW][col] = pix;
    hit = (row + 1 >= k) && (col + 1 >= k);
    res.med = '0;
    res.last = 1'b0;
    if (hit) begin
      n = 0;
      top = row + 1 - k;
      left = col + 1 - k;
      for (int r = 0; r < k; r++) begin
        slot = (top + r) % MAX_WINDOW;
        for (int c = 0; c < k; c++) win[n++] = line_mem[slot][left + c];
      end
      for (int i = 1; i < n; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      res.med = win[n/2];
      res.last = (row == h - 1) && (col == w - 1);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    return hit;
  endfunction

  task automatic quiet_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    quiet_input();
    wait (medians_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    model_config(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Offers one pixel word; leaves tvalid high after it is taken.
  task automatic send_pixel(pix_t pix, bit typed = 0, bit has_res = 0,
                            pix_t med = '0, logic last = 1'b0);
    median_t r;
    bit hit;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(99) < 34) s_axis_tvalid <= 1'b0;
      else break;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    do @(posedge clk); while (!s_axis_tready);
    hit = filter_pixel(pix, r);
    if (typed) begin
      r.med = med;
      r.last = last;
      hit = has_res;
    end
    if (hit) medians_due.push_back(r);
    pixels_sent++;
  endtask

  function automatic void add_cfg(logic [1:0] idx, logic [12:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1;
    s.idx = idx;
    s.val = val;
    plan.push_back(s);
  endfunction

  function automatic void add_pix(pix_t pix, bit typed = 0, bit has_res = 0,
                                  pix_t med = '0, logic last = 1'b0);
    step_t s;
    s = '{default: '0};
    s.pix = pix;
    s.typed = typed;
    s.has_res = has_res;
    s.med = med;
    s.last = last;
    plan.push_back(s);
  endfunction

  function automatic pix_t rand_pix();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return pix_t'($urandom_range(7));
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(int w, int h, int k, int count);
    int order;
    order = $urandom_range(1);
    if (order) write_reg(REG_WINDOW, 13'(k));
    write_reg(REG_WIDTH, 13'(w));
    write_reg(REG_HEIGHT, 13'(h));
    if (!order) write_reg(REG_WINDOW, 13'(k));
    if ($urandom_range(9) == 0) write_reg(REG_SPARE, 13'($urandom));
    for (int i = 0; i < count; i++) send_pixel(rand_pix());
  endtask

  initial begin
    int w, h, k, frames;
    model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // One-pixel frames pass the pixel straight through as the frame end.
    add_cfg(REG_WIDTH, 13'd1);
    add_cfg(REG_HEIGHT, 13'd1);
    add_cfg(REG_WINDOW, 13'd1);
    add_pix(16'h0000, 1, 1, 16'h0000, 1'b1);
    add_pix(16'hFFFF, 1, 1, 16'hFFFF, 1'b1);
    // Zero sizes saturate to one.
    add_cfg(REG_WIDTH, 13'd0);
    add_cfg(REG_HEIGHT, 13'd0);
    add_cfg(REG_WINDOW, 13'd0);
    add_pix(16'hAAAA, 1, 1, 16'hAAAA, 1'b1);
    // A write to the unused index must not restart anything.
    add_cfg(REG_SPARE, 13'h1FFF);
    add_pix(16'h5555, 1, 1, 16'h5555, 1'b1);
    // Even window: the upper median of 1,4,2,3 is 3.
    add_cfg(REG_WIDTH, 13'd2);
    add_cfg(REG_HEIGHT, 13'd2);
    add_cfg(REG_WINDOW, 13'd2);
    add_pix(16'd1, 1, 0);
    add_pix(16'd4, 1, 0);
    add_pix(16'd2, 1, 0);
    add_pix(16'd3, 1, 1, 16'd3, 1'b1);
    // Window larger than the frame yields nothing.
    add_cfg(REG_WINDOW, 13'd7);
    for (int i = 0; i < 4; i++) add_pix(16'h8000, 1, 0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_pixel(plan[i].pix, plan[i].typed, plan[i].has_res,
                      plan[i].med, plan[i].last);
    end

    // Sink holds off while pixels keep coming, so the input must stall.
    random_phase(3, 40, 1, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) send_pixel(rand_pix());
    drain();

    // A long stretch with both sides always ready.
    no_idle = 1'b1;
    random_phase(10, 10, 3, 100);
    no_idle = 1'b0;

    // Oversized width and height saturate.
    random_phase(2047, 2, 2, 150);
    random_phase(5, 8191, 1, 12);

    while (pixels_sent < 950) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 9);
      k = $urandom_range(1, 7);
      frames = $urandom_range(1, 2);
      no_idle = ($urandom_range(11) == 0);
      random_phase(w, h, k, w * h * frames + (($urandom_range(3) == 0) ? $urandom_range(w) : 0));
      if ($urandom_range(5) == 0) drain();
    end
    no_idle = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/swmf_pkg.sv
rtl/swmf_median.sv
rtl/sliding_window_median_filter_2d.sv
rtl/swmf_checker.sv
tb/tb_top.sv
